/* src/whole_word_text_search_macros.svh */
// Assertion macros used by the checker of this block.
`ifndef WHOLE_WORD_TEXT_SEARCH_MACROS_SVH
`define WHOLE_WORD_TEXT_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WWS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("whole_word_text_search: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("whole_word_text_search: assertion failed");

`endif

/* src/wws_pkg.sv */
`timescale 1ns / 1ps
package wws_pkg;

    localparam int PB      = 32;
    localparam int PW      = 5;
    localparam int MW      = 16;
    localparam int LEN_W   = 6;
    localparam int LINE_W  = 24;
    localparam int POS_W   = 16;
    localparam int IDX_W   = 17;
    localparam int CMD_W   = 64;
    localparam int CFG_W   = 3;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef enum logic [CFG_W-1:0] {
        CFG_CMD0 = 3'd0,
        CFG_CMD1 = 3'd1,
        CFG_CMD2 = 3'd2,
        CFG_CMD3 = 3'd3,
        CFG_LEN  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_PHRASE,
        MODE_SEVERAL,
        MODE_PAIR
    } mode_t;

    typedef enum logic [1:0] {
        KIND_OCC  = 2'd0,
        KIND_LINE = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t                    mode;
        logic                     ok;
        logic [PB-1:0]            first;
        logic [PB-1:0]            body;
        logic [PB-1:0]            endm;
        logic [PB-1:0][PW-1:0]    widx;
        logic [MW-1:0]            allm;
        logic [PW-1:0]            e0;
        logic [PW-1:0]            e1;
        logic [LEN_W-1:0]         l0;
        logic [LEN_W-1:0]         l1;
        logic [PB-1:0][7:0]       lc;
    } dec_t;

    typedef struct packed {
        kind_t              kind;
        logic [LINE_W-1:0]  line;
        logic [POS_W-1:0]   idx;
        logic               last;
    } rec_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } push_t;

    function automatic logic [7:0] lower_of(input logic [7:0] x);
        lower_of = (x >= 8'h41 && x <= 8'h5a) ? x + CASE_DIFF : x;
    endfunction

endpackage

/* src/wws_decode.sv */
`timescale 1ns / 1ps
module wws_decode
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wws_pkg::CFG_W-1:0]        cfg_index,
    input  logic [wws_pkg::CMD_W-1:0]        cfg_data,
    output wws_pkg::dec_t                    dec
);

    logic [3:0][wws_pkg::CMD_W-1:0] cmd_reg;
    logic [wws_pkg::LEN_W-1:0]      len_reg;
    wws_pkg::dec_t                  dec_reg;
    wws_pkg::dec_t                  dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= '0;
            len_reg <= '0;
            dec_reg <= '0;
        end
        else
        begin
            dec_reg <= dec_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    wws_pkg::CFG_CMD0: cmd_reg[0] <= cfg_data;
                    wws_pkg::CFG_CMD1: cmd_reg[1] <= cfg_data;
                    wws_pkg::CFG_CMD2: cmd_reg[2] <= cfg_data;
                    wws_pkg::CFG_CMD3: cmd_reg[3] <= cfg_data;
                    wws_pkg::CFG_LEN:  len_reg    <= cfg_data[wws_pkg::LEN_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    assign dec = dec_reg;

    logic [wws_pkg::PB-1:0][7:0]     cb;
    logic [wws_pkg::LEN_W-1:0]       len;
    logic [wws_pkg::PB-1:0]          inlen, is_sp, is_st;
    logic [wws_pkg::PW-1:0]          fpos;
    logic                            fstar, any_delim, adj_sp, last_sp;
    logic [wws_pkg::LEN_W-1:0]       sc, wcount, lenm1, fpos6;

    always_comb
    begin
        cb  = cmd_reg;
        len = (len_reg > wws_pkg::LEN_W'(wws_pkg::PB)) ? wws_pkg::LEN_W'(wws_pkg::PB) : len_reg;
        lenm1 = len - 6'd1;
        for (int p = 0; p < wws_pkg::PB; p++)
        begin
            inlen[p] = wws_pkg::LEN_W'(p) < len;
            is_sp[p] = inlen[p] && cb[p] == wws_pkg::CH_SPACE;
            is_st[p] = inlen[p] && cb[p] == wws_pkg::CH_STAR;
        end
        any_delim = |(is_sp | is_st);
        fpos  = '0;
        fstar = 1'b0;
        for (int p = wws_pkg::PB - 1; p >= 0; p--)
        begin
            if (is_sp[p] || is_st[p])
            begin
                fpos  = wws_pkg::PW'(p);
                fstar = is_st[p];
            end
        end
        fpos6 = {1'b0, fpos};
        adj_sp  = 1'b0;
        last_sp = 1'b0;
        for (int p = 0; p < wws_pkg::PB; p++)
        begin
            if (p < wws_pkg::PB - 1)
                adj_sp = adj_sp | (is_sp[p] & is_sp[p+1]);
            last_sp = last_sp | (is_sp[p] && wws_pkg::LEN_W'(p) == lenm1);
        end
        sc     = wws_pkg::LEN_W'($countones(is_sp));
        wcount = sc + 6'd1;

        dec_next = '0;
        for (int p = 0; p < wws_pkg::PB; p++)
            dec_next.lc[p] = wws_pkg::lower_of(cb[p]);

        if (len != '0 && cb[0] == wws_pkg::CH_QUOTE)
        begin
            dec_next.mode = wws_pkg::MODE_PHRASE;
            dec_next.ok   = len >= 6'd3;
            dec_next.first[1] = 1'b1;
            for (int p = 1; p < wws_pkg::PB; p++)
                dec_next.body[p] = wws_pkg::LEN_W'(p + 1) < len;
            dec_next.e0 = wws_pkg::PW'(len - 6'd2);
            dec_next.l0 = len - 6'd2;
        end
        else if (!any_delim)
        begin
            dec_next.mode = wws_pkg::MODE_SINGLE;
            dec_next.ok   = len != '0;
            dec_next.first[0] = 1'b1;
            dec_next.body = inlen;
            dec_next.e0 = wws_pkg::PW'(lenm1);
            dec_next.l0 = len;
        end
        else if (fstar)
        begin
            dec_next.mode = wws_pkg::MODE_PAIR;
            dec_next.ok   = fpos != '0 && fpos6 + 6'd2 <= len;
            dec_next.first[0] = 1'b1;
            for (int p = 0; p < wws_pkg::PB; p++)
            begin
                dec_next.body[p] = inlen[p] && wws_pkg::PW'(p) != fpos;
                if (wws_pkg::PW'(p) == fpos + 5'd1 && p != 0)
                    dec_next.first[p] = 1'b1;
            end
            dec_next.e0 = fpos - 5'd1;
            dec_next.e1 = wws_pkg::PW'(lenm1);
            dec_next.l0 = fpos6;
            dec_next.l1 = lenm1 - fpos6;
        end
        else
        begin
            dec_next.mode = wws_pkg::MODE_SEVERAL;
            dec_next.ok   = !is_sp[0] && !last_sp && !adj_sp && wcount <= 6'(wws_pkg::MW);
            dec_next.first[0] = 1'b1;
            for (int p = 0; p < wws_pkg::PB; p++)
            begin
                if (p > 0)
                    dec_next.first[p] = inlen[p] && is_sp[p-1];
                dec_next.body[p] = inlen[p] && !is_sp[p];
                dec_next.endm[p] = inlen[p] && !is_sp[p] &&
                    (wws_pkg::LEN_W'(p) == lenm1 || (p < wws_pkg::PB - 1 && is_sp[p+1]));
                dec_next.widx[p] = wws_pkg::PW'($countones(is_sp & ((32'd1 << p) - 32'd1)));
            end
            for (int w = 0; w < wws_pkg::MW; w++)
                dec_next.allm[w] = wws_pkg::LEN_W'(w) < wcount;
        end

        if (!dec_next.ok)
        begin
            dec_next.first = '0;
            dec_next.body  = '0;
            dec_next.endm  = '0;
        end
    end

endmodule

/* src/wws_core.sv */
`timescale 1ns / 1ps
module wws_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic [0:0]      s_tuser,
    input  wws_pkg::dec_t   dec,
    input  logic            room,
    output wws_pkg::push_t  push
);

    logic                        s0_valid_reg, s0_valid_next;
    logic [7:0]                  byte_reg;
    logic                        eot_reg;

    logic [wws_pkg::PB-1:0]      mv_reg, mv_next;
    logic [wws_pkg::MW-1:0]      wf_reg, wf_next;
    logic [wws_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [wws_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        aws_reg, aws_next;
    logic                        lv_reg, lv_next, rv_reg, rv_next;
    logic [wws_pkg::IDX_W-1:0]   fl_reg, fl_next, lr_reg, lr_next;

    logic                        fire, delim, is_nl, hit0, hit1, occ, close_hit, line_hit;
    logic [wws_pkg::LINE_W-1:0]  line_now;
    logic [wws_pkg::POS_W-1:0]   start0, start1;
    logic [wws_pkg::MW-1:0]      found, wf_u;
    logic                        lv_u, rv_u;
    logic [wws_pkg::IDX_W-1:0]   fl_u, lr_u;
    logic [wws_pkg::PB-1:0]      eq, shifted;
    logic [7:0]                  lc_in;
    wws_pkg::rec_t               rec_occ, rec_line, rec_done;

    assign fire          = s0_valid_reg && room;
    assign s_tready      = !s0_valid_reg || fire;
    assign s0_valid_next = s_tready ? s_tvalid : s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= s0_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tuser[0];
        end
    end

    always_comb
    begin
        is_nl = !eot_reg && byte_reg == wws_pkg::CH_NL;
        delim = eot_reg || byte_reg == wws_pkg::CH_SPACE || byte_reg == wws_pkg::CH_NL ||
                byte_reg == wws_pkg::CH_NUL;
        line_now = (line_reg == wws_pkg::LINE_MAX) ? wws_pkg::LINE_MAX : line_reg + 24'd1;
        hit0 = dec.ok && delim && mv_reg[dec.e0];
        hit1 = dec.ok && delim && mv_reg[dec.e1];
        start0 = (pos_reg >= {10'd0, dec.l0}) ? pos_reg - {10'd0, dec.l0} : '0;
        start1 = (pos_reg >= {10'd0, dec.l1}) ? pos_reg - {10'd0, dec.l1} : '0;

        occ = hit0 && (dec.mode == wws_pkg::MODE_SINGLE || dec.mode == wws_pkg::MODE_PHRASE);

        found = '0;
        for (int w = 0; w < wws_pkg::MW; w++)
            for (int p = 0; p < wws_pkg::PB; p++)
                found[w] = found[w] |
                    (mv_reg[p] && dec.endm[p] && dec.widx[p] == wws_pkg::PW'(w));
        wf_u = wf_reg;
        if (dec.ok && delim && dec.mode == wws_pkg::MODE_SEVERAL)
            wf_u = wf_reg | found;

        lv_u = lv_reg;
        fl_u = fl_reg;
        rv_u = rv_reg;
        lr_u = lr_reg;
        if (dec.mode == wws_pkg::MODE_PAIR)
        begin
            if (hit0 && !lv_reg)
            begin
                lv_u = 1'b1;
                fl_u = {1'b0, start0};
            end
            if (hit1)
            begin
                rv_u = 1'b1;
                lr_u = {1'b0, start1};
            end
        end

        close_hit = 1'b0;
        if (dec.ok && dec.mode == wws_pkg::MODE_SEVERAL)
            close_hit = (wf_u & dec.allm) == dec.allm;
        else if (dec.ok && dec.mode == wws_pkg::MODE_PAIR)
            close_hit = lv_u && rv_u && (fl_u + {11'd0, dec.l0} + 17'd1 != lr_u) && fl_u < lr_u;
        line_hit = close_hit && (eot_reg || is_nl);

        rec_occ  = '{kind: wws_pkg::KIND_OCC, line: line_now, idx: start0, last: !eot_reg};
        rec_line = '{kind: wws_pkg::KIND_LINE, line: line_now, idx: '0, last: !eot_reg};
        rec_done = '{kind: wws_pkg::KIND_DONE, line: '0, idx: '0, last: 1'b1};

        push.valid = fire;
        push.r1    = rec_done;
        if (occ)
        begin
            push.r0 = rec_occ;
            push.n  = eot_reg ? 2'd2 : 2'd1;
        end
        else if (line_hit)
        begin
            push.r0 = rec_line;
            push.n  = eot_reg ? 2'd2 : 2'd1;
        end
        else
        begin
            push.r0 = rec_done;
            push.n  = eot_reg ? 2'd1 : 2'd0;
        end

        lc_in = wws_pkg::lower_of(byte_reg);
        for (int p = 0; p < wws_pkg::PB; p++)
            eq[p] = dec.lc[p] == lc_in;
        shifted = (mv_reg << 1) & ~dec.first;
        if (aws_reg)
            shifted = shifted | dec.first;

        mv_next   = mv_reg;
        wf_next   = wf_reg;
        line_next = line_reg;
        pos_next  = pos_reg;
        aws_next  = aws_reg;
        lv_next   = lv_reg;
        fl_next   = fl_reg;
        rv_next   = rv_reg;
        lr_next   = lr_reg;
        if (fire)
        begin
            if (eot_reg || is_nl)
            begin
                line_next = eot_reg ? '0 : line_now;
                mv_next   = '0;
                wf_next   = '0;
                pos_next  = '0;
                aws_next  = 1'b1;
                lv_next   = 1'b0;
                fl_next   = '0;
                rv_next   = 1'b0;
                lr_next   = '0;
            end
            else
            begin
                mv_next  = shifted & dec.body & eq;
                wf_next  = wf_u;
                pos_next = (pos_reg == wws_pkg::POS_MAX) ? pos_reg : pos_reg + 16'd1;
                aws_next = byte_reg == wws_pkg::CH_SPACE;
                lv_next  = lv_u;
                fl_next  = fl_u;
                rv_next  = rv_u;
                lr_next  = lr_u;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= '0;
            wf_reg   <= '0;
            line_reg <= '0;
            pos_reg  <= '0;
            aws_reg  <= 1'b1;
            lv_reg   <= 1'b0;
            fl_reg   <= '0;
            rv_reg   <= 1'b0;
            lr_reg   <= '0;
        end
        else
        begin
            mv_reg   <= mv_next;
            wf_reg   <= wf_next;
            line_reg <= line_next;
            pos_reg  <= pos_next;
            aws_reg  <= aws_next;
            lv_reg   <= lv_next;
            fl_reg   <= fl_next;
            rv_reg   <= rv_next;
            lr_reg   <= lr_next;
        end
    end

endmodule

/* src/wws_outq.sv */
`timescale 1ns / 1ps
module wws_outq
(
    input  logic            clk,
    input  logic            rst_n,
    input  wws_pkg::push_t  push,
    output logic            room,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    wws_pkg::rec_t q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          pop;

    assign m_tvalid = cnt_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    // a push only lands on a queue that is empty after this cycle's pop
    assign room     = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop);

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (push.valid)
        begin
            q0_next  = push.r0;
            q1_next  = push.r1;
            cnt_next = push.n;
        end
        else if (pop)
        begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tdata = {q0_reg.idx, q0_reg.line};
    assign m_tuser = q0_reg.kind;
    assign m_tlast = q0_reg.last;

endmodule

/* src/whole_word_text_search.sv */
`timescale 1ns / 1ps
// An input beat is first registered, then its records are written into the
// result queue. Throughput: one beat per cycle while the output is ready;
// an item with two results holds the input while the two-entry queue drains.
// Command decode is registered from the config-written command registers.
// Reset (rst_n low, async) clears config, line state and the result queue.
module whole_word_text_search
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] text_byte
    input  logic [0:0]    s_tuser,   // [0] end_of_text
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // [23:0] line_number, [39:24] char_index
    output logic [1:0]    m_tuser,   // [1:0] record_kind
    output logic          m_tlast,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    wws_pkg::dec_t  dec;
    wws_pkg::push_t push;
    logic           room;

    wws_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dec       (dec)
    );

    wws_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .dec      (dec),
        .room     (room),
        .push     (push)
    );

    wws_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/wws_checker.sv */
`timescale 1ns / 1ps
`include "whole_word_text_search_macros.svh"
module wws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `WWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `WWS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `WWS_ASSERT_NOW(a_done_last, m_tvalid && m_tuser == wws_pkg::KIND_DONE, m_tlast && m_tdata == 40'd0)
    `WWS_ASSERT_NOW(a_line_idx, m_tvalid && m_tuser == wws_pkg::KIND_LINE, m_tdata[39:24] == 16'd0 && m_tdata[23:0] != 24'd0)

endmodule

bind whole_word_text_search wws_checker u_wws_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import wws_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    whole_word_text_search dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // predictor copy of registers and per-text state
    logic [63:0] cmd_reg [4];
    logic [5:0]  cmd_len;
    mode_t       cmd_mode;
    bit          cmd_ok;
    int          word_cnt;
    int          word_lo [18];
    int          word_hi [18];
    bit [63:0]   first_bits;
    bit [63:0]   body_bits;

    bit [63:0]   hit_vec;
    bit [31:0]   words_seen;
    bit [23:0]   lines_done;
    bit [15:0]   col;
    bit          word_start;
    bit          left_seen;
    bit          right_seen;
    int unsigned left_col;
    int unsigned right_col;

    rec_t        expected_records [$];
    rec_t        step_records [$];

    bit          idle_on;
    int          stall_left;
    int          errors;
    int          beats_in;
    int          beats_out;
    int          commands_run;
    int          quiet_cycles;

    function automatic logic [7:0] fold_case(logic [7:0] x);
        if (x >= "A" && x <= "Z")
            return x + 8'd32;
        return x;
    endfunction

    function automatic logic [7:0] cmd_byte(int i);
        if (i < 0 || i >= PB)
            return 8'h00;
        return cmd_reg[i >> 3][(i & 7) * 8 +: 8];
    endfunction

    task automatic add_word(int lo, int hi);
        if (hi < lo || word_cnt >= 18)
            cmd_ok = 1'b0;
        else
        begin
            word_lo[word_cnt] = lo;
            word_hi[word_cnt] = hi;
            word_cnt++;
        end
    endtask

    task automatic decode_command();
        int len;
        int i;
        int s;
        int w;
        len = (cmd_len > PB) ? PB : cmd_len;
        cmd_ok = 1'b1;
        cmd_mode = MODE_SINGLE;
        word_cnt = 0;
        first_bits = '0;
        body_bits = '0;
        if (len > 0 && cmd_byte(0) == CH_QUOTE)
        begin
            cmd_mode = MODE_PHRASE;
            add_word(1, len - 2);
        end
        else
        begin
            for (i = 0; i < len; i++)
            begin
                if (cmd_byte(i) == CH_STAR)
                begin
                    cmd_mode = MODE_PAIR;
                    break;
                end
                if (cmd_byte(i) == CH_SPACE)
                begin
                    cmd_mode = MODE_SEVERAL;
                    break;
                end
            end
            if (cmd_mode == MODE_SINGLE)
                add_word(0, len - 1);
            else if (cmd_mode == MODE_PAIR)
            begin
                add_word(0, i - 1);
                add_word(i + 1, len - 1);
            end
            else
            begin
                s = 0;
                for (i = 0; i <= len; i++)
                begin
                    if (i == len || cmd_byte(i) == CH_SPACE)
                    begin
                        add_word(s, i - 1);
                        s = i + 1;
                    end
                end
                if (word_cnt > MW)
                    cmd_ok = 1'b0;
            end
        end
        if (cmd_ok)
        begin
            for (w = 0; w < word_cnt; w++)
            begin
                first_bits |= 64'd1 << word_lo[w];
                for (i = word_lo[w]; i <= word_hi[w]; i++)
                    body_bits |= 64'd1 << i;
            end
        end
    endtask

    function automatic logic [23:0] line_now();
        return (lines_done == LINE_MAX) ? LINE_MAX : lines_done + 24'd1;
    endfunction

    task automatic add_record(kind_t k, logic [23:0] ln, logic [15:0] ix);
        rec_t r;
        r.kind = k;
        r.line = ln;
        r.idx = ix;
        r.last = 1'b0;
        step_records.push_back(r);
    endtask

    task automatic clear_line();
        hit_vec = '0;
        words_seen = '0;
        col = '0;
        word_start = 1'b1;
        left_seen = 1'b0;
        right_seen = 1'b0;
        left_col = 0;
        right_col = 0;
    endtask

    task automatic finish_words();
        int w;
        int unsigned wl;
        int unsigned st;
        if (cmd_ok)
        begin
            for (w = 0; w < word_cnt; w++)
            begin
                wl = word_hi[w] - word_lo[w] + 1;
                if (!hit_vec[word_hi[w]])
                    continue;
                st = (col >= wl) ? col - wl : 0;
                if (cmd_mode == MODE_SINGLE || cmd_mode == MODE_PHRASE)
                    add_record(KIND_OCC, line_now(), st[15:0]);
                else if (cmd_mode == MODE_SEVERAL)
                    words_seen[w] = 1'b1;
                else if (w == 0)
                begin
                    if (!left_seen)
                    begin
                        left_seen = 1'b1;
                        left_col = st;
                    end
                end
                else
                begin
                    right_seen = 1'b1;
                    right_col = st;
                end
            end
        end
    endtask

    task automatic close_line();
        bit hit;
        bit [31:0] all;
        int unsigned len1;
        hit = 1'b0;
        if (cmd_ok)
        begin
            if (cmd_mode == MODE_SEVERAL)
            begin
                all = (32'd1 << word_cnt) - 32'd1;
                hit = (words_seen & all) == all;
            end
            else if (cmd_mode == MODE_PAIR)
            begin
                len1 = word_hi[0] - word_lo[0] + 1;
                hit = left_seen && right_seen && (left_col + len1 + 1 != right_col)
                      && (left_col < right_col);
            end
            if (hit)
                add_record(KIND_LINE, line_now(), 16'd0);
        end
    endtask

    task automatic search_predict(logic [7:0] c, bit eot);
        bit [63:0] eq;
        bit [63:0] nxt;
        int i;
        rec_t r;
        step_records.delete();
        decode_command();
        if (eot)
        begin
            finish_words();
            close_line();
            add_record(KIND_DONE, 24'd0, 16'd0);
            lines_done = '0;
            clear_line();
        end
        else
        begin
            eq = '0;
            if (c == CH_SPACE || c == CH_NL || c == CH_NUL)
                finish_words();
            for (i = 0; i < PB; i++)
                if (fold_case(cmd_byte(i)) == fold_case(c))
                    eq[i] = 1'b1;
            nxt = (hit_vec << 1) & ~first_bits;
            if (word_start)
                nxt |= first_bits;
            hit_vec = nxt & body_bits & eq;
            if (c == CH_NL)
            begin
                close_line();
                if (lines_done != LINE_MAX)
                    lines_done++;
                clear_line();
            end
            else
            begin
                if (col != POS_MAX)
                    col++;
                word_start = (c == CH_SPACE);
            end
        end
        for (i = 0; i < step_records.size(); i++)
        begin
            r = step_records[i];
            r.last = (i == step_records.size() - 1);
            expected_records.push_back(r);
        end
    endtask

    task automatic send_beat(logic [7:0] c, bit eot);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= eot;
        do
            @(posedge clk);
        while (!s_tready);
        search_predict(c, eot);
        beats_in++;
    endtask

    task automatic send_text(string t);
        int i;
        for (i = 0; i < t.len(); i++)
            send_beat(t[i], 1'b0);
    endtask

    task automatic end_text();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_records.size() == 0);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        if (idx == CFG_LEN)
            cmd_len = d[5:0];
        else
            cmd_reg[idx] = d;
    endtask

    task automatic load_raw(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] r3, logic [63:0] len);
        drain();
        write_reg(CFG_CMD0, r0);
        write_reg(CFG_CMD1, r1);
        write_reg(CFG_CMD2, r2);
        write_reg(CFG_CMD3, r3);
        write_reg(CFG_LEN, len);
        cfg_we <= 1'b0;
        repeat (3) @(posedge clk);
        commands_run++;
    endtask

    task automatic load_command(string s);
        logic [63:0] r [4];
        int i;
        r = '{default: '0};
        for (i = 0; i < s.len() && i < PB; i++)
            r[i / 8][(i % 8) * 8 +: 8] = s[i];
        load_raw(r[0], r[1], r[2], r[3], 64'(s.len()));
    endtask

    function automatic string random_word();
        string pool [6];
        string w;
        int i;
        pool = '{"ab", "ba", "a", "abc", "xy", "b"};
        w = pool[$urandom_range(0, 5)];
        for (i = 0; i < w.len(); i++)
            if ($urandom_range(0, 2) == 0)
                w[i] = w[i] - 8'd32;
        return w;
    endfunction

    function automatic string random_command();
        case ($urandom_range(0, 4))
            0: return random_word();
            1: return {"\"", random_word(), " ", random_word(), "\""};
            2: return {random_word(), " ", random_word(), " ", random_word()};
            3: return {random_word(), "*", random_word()};
            default: return {random_word(), " ", random_word()};
        endcase
    endfunction

    task automatic random_text(int n);
        int k;
        int r;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
            begin
                send_text(random_word());
                k += 2;
            end
            else if (r < 16)
                send_beat(CH_SPACE, 1'b0);
            else if (r < 18)
                send_beat(CH_NL, 1'b0);
            else if (r < 19)
                send_beat(CH_NUL, 1'b0);
            else
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            k++;
        end
        end_text();
    endtask

    task automatic test_single_word();
        load_command("Cat");
        send_text("cat CAT xcat cats cat\ncAt");
        send_beat(CH_NUL, 1'b0);
        send_text(" cat\n\n cat");
        end_text();
        end_text();
    endtask

    task automatic test_phrase();
        load_command("\"a B\"");
        send_text("a b A B ab b\nxa b a b");
        end_text();
    endtask

    task automatic test_several_words();
        load_command("foo bar");
        send_text("bar x foo\nfoo\nbarfoo foo bar\n");
        end_text();
    endtask

    task automatic test_pair();
        load_command("ab*cd");
        send_text("ab cd\nab x cd\ncd ab\nab*cd ab x cd ab cd");
        end_text();
    endtask

    task automatic test_empty_commands();
        load_command("");
        send_text("a \n");
        end_text();
        load_command("\"\"");
        send_text("\"\" x\n");
        end_text();
        load_command("a  b");
        send_text("a b\n");
        end_text();
        load_command("a*");
        send_text("a b\n");
        end_text();
    endtask

    task automatic test_extremes();
        load_raw('1, '1, '1, '1, 64'd63);
        send_beat(8'hff, 1'b0);
        send_beat(8'h00, 1'b0);
        end_text();
        load_raw('0, '0, '0, '0, 64'd0);
        send_beat(8'h00, 1'b0);
        end_text();
    endtask

    task automatic test_long_line();
        int i;
        load_command("q");
        idle_on = 1'b0;
        for (i = 0; i < 40; i++)
            send_beat("z", 1'b0);
        send_text(" q q\nq");
        end_text();
        idle_on = 1'b1;
    endtask

    task automatic test_random_commands();
        int p;
        for (p = 0; p < 14; p++)
        begin
            if (p % 5 == 4)
                load_raw({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 64'($urandom_range(0, 63)));
            else
                load_command(random_command());
            random_text(60);
        end
    endtask

    task automatic test_no_idle();
        int p;
        idle_on = 1'b0;
        for (p = 0; p < 3; p++)
        begin
            load_command(random_command());
            random_text(60);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left <= 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rec_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (expected_records.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: kind %0d line %0d idx %0d last %0d",
                         $time, m_tuser, m_tdata[23:0], m_tdata[39:24], m_tlast);
            end
            else
            begin
                exp_r = expected_records.pop_front();
                if (m_tuser != exp_r.kind || m_tdata[23:0] != exp_r.line ||
                    m_tdata[39:24] != exp_r.idx || m_tlast != exp_r.last)
                begin
                    errors++;
                    $display("%0t mismatch: expected kind %0d line %0d idx %0d last %0d",
                             $time, exp_r.kind, exp_r.line, exp_r.idx, exp_r.last);
                    $display("%0t           actual   kind %0d line %0d idx %0d last %0d",
                             $time, m_tuser, m_tdata[23:0], m_tdata[39:24], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_reg = '{default: '0};
        cmd_len = '0;
        lines_done = '0;
        clear_line();
        idle_on = 1'b1;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        commands_run = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_word();
        test_phrase();
        test_several_words();
        test_pair();
        test_empty_commands();
        test_extremes();
        test_long_line();
        test_random_commands();
        test_no_idle();

        drain();
        repeat (10) @(posedge clk);
        $display("Covered %0d commands in all four search modes, %0d text beats in,",
                 commands_run, beats_in);
        $display("%0d result beats checked, incl. empty commands and raw random commands.",
                 beats_out);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
